FILE: sv/lpfe_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and constants of the lane potential field evaluator.
// Used by the controller, the datapath, the top level and the checker.
package lpfe_pkg;

	localparam int LPFE_MAX_POINTS = 64;
	localparam int LPFE_FRAC_BITS  = 16;
	localparam int GAIN_FRAC_BITS  = 16;

	localparam int IN_DATA_W  = 96;
	localparam int IN_USER_W  = 2;
	localparam int OUT_DATA_W = 48;
	localparam int OUT_USER_W = 2;
	localparam int CFG_ADDR_W = 2;
	localparam int CFG_DATA_W = 32;

	localparam logic [47:0] POT_MAX = 48'hFFFF_FFFF_FFFF;

	localparam logic [31:0] ATTRACT_GAIN_RST = 32'd65536;
	localparam logic [31:0] REPEL_GAIN_RST   = 32'd65536;
	localparam logic [30:0] REPEL_RANGE_RST  = 31'd32768;

	typedef enum logic [1:0] {
		REQ_CLEAR  = 2'd0,
		REQ_LOAD_L = 2'd1,
		REQ_LOAD_R = 2'd2,
		REQ_QUERY  = 2'd3
	} lpfe_req_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_FULL = 2'd1,
		ST_SAT  = 2'd2
	} lpfe_status_t;

	typedef enum logic [1:0] {
		CFG_ATTRACT_GAIN = 2'd0,
		CFG_REPEL_GAIN   = 2'd1,
		CFG_REPEL_RANGE  = 2'd2
	} lpfe_cfg_idx_t;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_CLEAR,
		OP_LOAD,
		OP_LATCH,
		OP_MUL_LIM,
		OP_SET_LIM,
		OP_READ,
		OP_DIF_MID,
		OP_DIF_PT,
		OP_MUL_SQ,
		OP_ACC,
		OP_BEST,
		OP_CHK,
		OP_SQRT,
		OP_MUL_DEN,
		OP_DIV_INIT,
		OP_DIV,
		OP_MUL_U,
		OP_SET_V,
		OP_MUL_V,
		OP_ADD_TERM,
		OP_RES_Q
	} lpfe_op_t;

	typedef struct packed {
		lpfe_op_t   op;
		logic [1:0] part;
		logic [1:0] sh;
		logic       clr;
		logic       first;
		logic       attract;
		logic       right;
		logic       full;
	} lpfe_cmd_t;

	typedef struct packed {
		logic skip;
		logic bad;
	} lpfe_sts_t;

endpackage

FILE: sv/lane_potential_field_eval_unit.sv
`timescale 1ns / 1ps
// Lane potential field evaluator. Clear and load beats give their result in
// the next cycle. A query walks the centerline points and then each boundary
// point; a boundary point in range goes through the bit-serial square root
// and divider and the one multiplier, while one out of range or whose distance
// rounds to zero is skipped. One beat is in work at a time. Reset clears
// counts and handshakes and restores the gain and range defaults.
module lane_potential_field_eval_unit #(
	parameter int MAX_LANE_POINTS = lpfe_pkg::LPFE_MAX_POINTS,
	parameter int COORD_FRAC_BITS = lpfe_pkg::LPFE_FRAC_BITS
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// coord_x [31:0], coord_y [63:32], coord_z [95:64]
	input  logic [lpfe_pkg::IN_DATA_W-1:0]  s_tdata,
	// req_type [1:0]
	input  logic [lpfe_pkg::IN_USER_W-1:0]  s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// potential [47:0]
	output logic [lpfe_pkg::OUT_DATA_W-1:0] m_tdata,
	// status [1:0]
	output logic [lpfe_pkg::OUT_USER_W-1:0] m_tuser,
	input  logic                            cfg_we,
	input  logic [lpfe_pkg::CFG_ADDR_W-1:0] cfg_addr,
	input  logic [lpfe_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import lpfe_pkg::*;

	localparam int AW = (MAX_LANE_POINTS > 1) ? $clog2(MAX_LANE_POINTS) : 1;

	lpfe_cmd_t    cmd;
	lpfe_sts_t    sts;
	logic [AW-1:0] addr;
	lpfe_status_t status;

	assign m_tuser = status;

	lpfe_ctrl #(
		.MAX_LANE_POINTS(MAX_LANE_POINTS),
		.COORD_FRAC_BITS(COORD_FRAC_BITS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.req      (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd),
		.addr     (addr),
		.sts      (sts)
	);

	lpfe_dp #(
		.MAX_LANE_POINTS(MAX_LANE_POINTS),
		.COORD_FRAC_BITS(COORD_FRAC_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.addr      (addr),
		.coords    (s_tdata),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.sts       (sts),
		.potential (m_tdata),
		.status    (status)
	);

endmodule

FILE: sv/lpfe_ctrl.sv
`timescale 1ns / 1ps
// Controller of the lane potential field evaluator: handshakes, store counts
// and the sequence of datapath commands. Depends on lpfe_pkg.
module lpfe_ctrl #(
	parameter int MAX_LANE_POINTS = 64,
	parameter int COORD_FRAC_BITS = 16,
	localparam int AW = (MAX_LANE_POINTS > 1) ? $clog2(MAX_LANE_POINTS) : 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [1:0]          req,
	output logic                m_tvalid,
	input  logic                m_tready,
	output lpfe_pkg::lpfe_cmd_t cmd,
	output logic [AW-1:0]       addr,
	input  lpfe_pkg::lpfe_sts_t sts
);
	import lpfe_pkg::*;

	localparam int CW        = $clog2(MAX_LANE_POINTS + 1);
	localparam int DIV_STEPS = 31 + 2 * COORD_FRAC_BITS;
	localparam int SW        = $clog2(DIV_STEPS);

	typedef enum logic [21:0] {
		S_IDLE  = 22'h000001,
		S_QINIT = 22'h000002,
		S_QLIM  = 22'h000004,
		S_RD    = 22'h000008,
		S_DIF   = 22'h000010,
		S_SQ    = 22'h000020,
		S_AC    = 22'h000040,
		S_BEST  = 22'h000080,
		S_BNEXT = 22'h000100,
		S_CHK   = 22'h000200,
		S_SQRT  = 22'h000400,
		S_DTST  = 22'h000800,
		S_MDEN  = 22'h001000,
		S_DINI  = 22'h002000,
		S_DIV   = 22'h004000,
		S_UMUL  = 22'h008000,
		S_UAC   = 22'h010000,
		S_VSET  = 22'h020000,
		S_SMUL  = 22'h040000,
		S_SAC   = 22'h080000,
		S_SADD  = 22'h100000,
		S_FIN   = 22'h200000
	} state_t;

	state_t        state_q, state_nxt;
	logic [CW-1:0] lc_q, rc_q, idx_q, lc_nxt, rc_nxt, idx_nxt, n_pts;
	logic [SW-1:0] cnt_q, cnt_nxt;
	logic          right_q, right_nxt, attract_q, attract_nxt;
	logic          m_valid_q, out_free, accept, res_evt;

	assign out_free = !m_valid_q || m_tready;
	assign s_tready = (state_q == S_IDLE) && out_free;
	assign accept   = s_tvalid && s_tready;
	assign m_tvalid = m_valid_q;
	assign n_pts    = (lc_q < rc_q) ? lc_q : rc_q;

	always_comb begin
		state_nxt   = state_q;
		lc_nxt      = lc_q;
		rc_nxt      = rc_q;
		idx_nxt     = idx_q;
		cnt_nxt     = cnt_q;
		right_nxt   = right_q;
		attract_nxt = attract_q;
		res_evt     = 1'b0;
		addr        = idx_q[AW-1:0];
		cmd         = '0;
		cmd.op      = OP_NONE;
		cmd.attract = attract_q;
		cmd.right   = right_q;
		case (state_q)
			S_IDLE: begin
				cmd.right = (req == REQ_LOAD_R);
				if (accept) begin
					case (req)
						REQ_CLEAR: begin
							cmd.op  = OP_CLEAR;
							res_evt = 1'b1;
							lc_nxt  = '0;
							rc_nxt  = '0;
						end
						REQ_LOAD_L: begin
							cmd.op   = OP_LOAD;
							cmd.full = (lc_q == CW'(MAX_LANE_POINTS));
							addr     = lc_q[AW-1:0];
							res_evt  = 1'b1;
							if (!cmd.full) lc_nxt = lc_q + 1'b1;
						end
						REQ_LOAD_R: begin
							cmd.op   = OP_LOAD;
							cmd.full = (rc_q == CW'(MAX_LANE_POINTS));
							addr     = rc_q[AW-1:0];
							res_evt  = 1'b1;
							if (!cmd.full) rc_nxt = rc_q + 1'b1;
						end
						default: begin
							cmd.op    = OP_LATCH;
							state_nxt = S_QINIT;
						end
					endcase
				end
			end
			S_QINIT: begin
				cmd.op    = OP_MUL_LIM;
				state_nxt = S_QLIM;
			end
			S_QLIM: begin
				cmd.op      = OP_SET_LIM;
				idx_nxt     = '0;
				right_nxt   = 1'b0;
				attract_nxt = (n_pts != '0);
				state_nxt   = (n_pts != '0) ? S_RD : S_BNEXT;
			end
			S_RD: begin
				cmd.op    = OP_READ;
				state_nxt = S_DIF;
			end
			S_DIF: begin
				cmd.op    = attract_q ? OP_DIF_MID : OP_DIF_PT;
				cnt_nxt   = '0;
				state_nxt = S_SQ;
			end
			S_SQ: begin
				cmd.op    = OP_MUL_SQ;
				cmd.part  = cnt_q[1:0];
				state_nxt = S_AC;
			end
			S_AC: begin
				cmd.op  = OP_ACC;
				cmd.clr = (cnt_q == '0);
				if (cnt_q == SW'(2)) begin
					state_nxt = attract_q ? S_BEST : S_CHK;
				end else begin
					cnt_nxt   = cnt_q + 1'b1;
					state_nxt = S_SQ;
				end
			end
			S_BEST: begin
				cmd.op    = OP_BEST;
				cmd.first = (idx_q == '0);
				if ((idx_q + 1'b1) < n_pts) begin
					idx_nxt   = idx_q + 1'b1;
					state_nxt = S_RD;
				end else begin
					state_nxt = S_VSET;
				end
			end
			S_BNEXT: begin
				if (!right_q && idx_q < lc_q) begin
					state_nxt = S_RD;
				end else if (!right_q) begin
					right_nxt = 1'b1;
					idx_nxt   = '0;
				end else if (idx_q < rc_q) begin
					state_nxt = S_RD;
				end else begin
					state_nxt = S_FIN;
				end
			end
			S_CHK: begin
				cmd.op  = OP_CHK;
				cnt_nxt = '0;
				if (sts.skip) begin
					idx_nxt   = idx_q + 1'b1;
					state_nxt = S_BNEXT;
				end else begin
					state_nxt = S_SQRT;
				end
			end
			S_SQRT: begin
				cmd.op = OP_SQRT;
				if (cnt_q == SW'(31)) state_nxt = S_DTST;
				else cnt_nxt = cnt_q + 1'b1;
			end
			S_DTST: begin
				if (sts.bad) begin
					idx_nxt   = idx_q + 1'b1;
					state_nxt = S_BNEXT;
				end else begin
					state_nxt = S_MDEN;
				end
			end
			S_MDEN: begin
				cmd.op    = OP_MUL_DEN;
				state_nxt = S_DINI;
			end
			S_DINI: begin
				cmd.op    = OP_DIV_INIT;
				cnt_nxt   = '0;
				state_nxt = S_DIV;
			end
			S_DIV: begin
				cmd.op = OP_DIV;
				if (cnt_q == SW'(DIV_STEPS - 1)) begin
					cnt_nxt   = '0;
					state_nxt = S_UMUL;
				end else begin
					cnt_nxt = cnt_q + 1'b1;
				end
			end
			S_UMUL: begin
				cmd.op    = OP_MUL_U;
				cmd.part  = cnt_q[1:0];
				state_nxt = S_UAC;
			end
			S_UAC: begin
				// Cross terms of the square land one word up, the high square two.
				cmd.op  = OP_ACC;
				cmd.clr = (cnt_q == '0);
				cmd.sh  = {cnt_q[1] & cnt_q[0], cnt_q[1] ^ cnt_q[0]};
				if (cnt_q == SW'(3)) begin
					state_nxt = S_VSET;
				end else begin
					cnt_nxt   = cnt_q + 1'b1;
					state_nxt = S_UMUL;
				end
			end
			S_VSET: begin
				cmd.op    = OP_SET_V;
				cnt_nxt   = '0;
				state_nxt = S_SMUL;
			end
			S_SMUL: begin
				cmd.op    = OP_MUL_V;
				cmd.part  = cnt_q[1:0];
				state_nxt = S_SAC;
			end
			S_SAC: begin
				cmd.op  = OP_ACC;
				cmd.clr = (cnt_q == '0);
				cmd.sh  = cnt_q[1:0];
				if (cnt_q == SW'(3)) begin
					state_nxt = S_SADD;
				end else begin
					cnt_nxt   = cnt_q + 1'b1;
					state_nxt = S_SMUL;
				end
			end
			S_SADD: begin
				cmd.op    = OP_ADD_TERM;
				state_nxt = S_BNEXT;
				if (attract_q) begin
					attract_nxt = 1'b0;
					right_nxt   = 1'b0;
					idx_nxt     = '0;
				end else begin
					idx_nxt = idx_q + 1'b1;
				end
			end
			S_FIN: begin
				if (out_free) begin
					cmd.op    = OP_RES_Q;
					res_evt   = 1'b1;
					state_nxt = S_IDLE;
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			lc_q      <= '0;
			rc_q      <= '0;
			idx_q     <= '0;
			cnt_q     <= '0;
			right_q   <= 1'b0;
			attract_q <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			state_q   <= state_nxt;
			lc_q      <= lc_nxt;
			rc_q      <= rc_nxt;
			idx_q     <= idx_nxt;
			cnt_q     <= cnt_nxt;
			right_q   <= right_nxt;
			attract_q <= attract_nxt;
			if (res_evt) m_valid_q <= 1'b1;
			else if (m_tready) m_valid_q <= 1'b0;
		end
	end

endmodule

FILE: sv/lpfe_dp.sv
`timescale 1ns / 1ps
// Datapath of the lane potential field evaluator: point stores, a shared
// 32x32 multiplier with a 128-bit accumulator, square root and divider steps.
// Depends on lpfe_pkg.
module lpfe_dp #(
	parameter int MAX_LANE_POINTS = 64,
	parameter int COORD_FRAC_BITS = 16,
	localparam int AW = (MAX_LANE_POINTS > 1) ? $clog2(MAX_LANE_POINTS) : 1
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  lpfe_pkg::lpfe_cmd_t     cmd,
	input  logic [AW-1:0]           addr,
	input  logic [95:0]             coords,
	input  logic                    cfg_we,
	input  logic [1:0]              cfg_addr,
	input  logic [31:0]             cfg_wdata,
	output lpfe_pkg::lpfe_sts_t     sts,
	output logic [47:0]             potential,
	output lpfe_pkg::lpfe_status_t  status
);
	import lpfe_pkg::*;

	localparam int NW = 31 + 2 * COORD_FRAC_BITS;
	localparam int OS = GAIN_FRAC_BITS + 1 + COORD_FRAC_BITS;
	localparam int PW = 48 + $clog2(2 * MAX_LANE_POINTS + 2);

	function automatic logic [31:0] abs_diff(input logic signed [31:0] a,
		input logic signed [31:0] b);
		logic signed [32:0] d;
		d = 33'(a) - 33'(b);
		return d[32] ? 32'(-d) : d[31:0];
	endfunction

	function automatic logic signed [31:0] mid_pt(input logic signed [31:0] a,
		input logic signed [31:0] b);
		logic signed [32:0] s;
		s = 33'(a) + 33'(b);
		return s[32:1];
	endfunction

	logic [95:0]   left_mem [MAX_LANE_POINTS];
	logic [95:0]   right_mem [MAX_LANE_POINTS];
	logic [95:0]   rd_l_q, rd_r_q, p_q;

	logic [31:0]   attract_gain_q, repel_gain_q;
	logic [30:0]   repel_range_q;

	logic [31:0]   dif_q [3];
	logic [31:0]   dif_nxt [3];
	logic [63:0]   prod_q, lim_q, x_q, res_q, bit_q, rem_q, den_q;
	logic [NW-1:0] quo_q;
	logic [127:0]  acc_q, v_q, acc_add;
	logic [65:0]   best_q;
	logic [PW-1:0] pot_q;
	logic          sat_q;
	logic [47:0]   pot_out_q;
	lpfe_status_t  stat_out_q;

	logic [31:0]   ma, mb, u_lo, u_hi, gain;
	logic [63:0]   u_w, root_try, rem_sh;
	logic          tsat, pot_big;
	logic [47:0]   term;

	assign u_w      = 64'(quo_q);
	assign u_lo     = u_w[31:0];
	assign u_hi     = u_w[63:32];
	assign gain     = cmd.attract ? attract_gain_q : repel_gain_q;
	assign root_try = res_q + bit_q;
	assign rem_sh   = {rem_q[62:0], quo_q[NW-1]};
	assign tsat     = |acc_q[127:48+OS];
	assign term     = tsat ? POT_MAX : acc_q[OS+47:OS];
	assign pot_big  = pot_q > PW'(POT_MAX);

	assign sts.skip = (repel_range_q == '0) || (|acc_q[127:64]) || (acc_q[63:0] >= lim_q);
	assign sts.bad  = (res_q == '0) || (res_q > 64'(repel_range_q));

	assign potential = pot_out_q;
	assign status    = stat_out_q;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			if (cmd.op == OP_DIF_MID)
				dif_nxt[k] = abs_diff(p_q[32*k +: 32],
					mid_pt(rd_l_q[32*k +: 32], rd_r_q[32*k +: 32]));
			else
				dif_nxt[k] = abs_diff(p_q[32*k +: 32],
					cmd.right ? rd_r_q[32*k +: 32] : rd_l_q[32*k +: 32]);
		end
	end

	always_comb begin
		ma = '0;
		mb = '0;
		case (cmd.op)
			OP_MUL_SQ: begin
				case (cmd.part)
					2'd0:    ma = dif_q[0];
					2'd1:    ma = dif_q[1];
					default: ma = dif_q[2];
				endcase
				mb = ma;
			end
			OP_MUL_LIM: begin
				ma = {1'b0, repel_range_q} + 32'd1;
				mb = ma;
			end
			OP_MUL_DEN: begin
				ma = res_q[31:0];
				mb = {1'b0, repel_range_q};
			end
			OP_MUL_U: begin
				ma = cmd.part[1] ? u_hi : u_lo;
				mb = cmd.part[0] ? u_hi : u_lo;
			end
			OP_MUL_V: begin
				ma = v_q[32*cmd.part +: 32];
				mb = gain;
			end
			default: ;
		endcase
	end

	always_comb begin
		case (cmd.sh)
			2'd0:    acc_add = {64'b0, prod_q};
			2'd1:    acc_add = {32'b0, prod_q, 32'b0};
			2'd2:    acc_add = {prod_q, 64'b0};
			default: acc_add = {prod_q[31:0], 96'b0};
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attract_gain_q <= ATTRACT_GAIN_RST;
			repel_gain_q   <= REPEL_GAIN_RST;
			repel_range_q  <= REPEL_RANGE_RST;
		end else if (cfg_we) begin
			case (cfg_addr)
				CFG_ATTRACT_GAIN: attract_gain_q <= cfg_wdata;
				CFG_REPEL_GAIN:   repel_gain_q   <= cfg_wdata;
				CFG_REPEL_RANGE:  repel_range_q  <= cfg_wdata[30:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_LOAD && !cmd.full) begin
			if (cmd.right) right_mem[addr] <= coords;
			else left_mem[addr] <= coords;
		end
		if (cmd.op == OP_READ) begin
			rd_l_q <= left_mem[addr];
			rd_r_q <= right_mem[addr];
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_CLEAR: begin
				pot_out_q  <= '0;
				stat_out_q <= ST_OK;
			end
			OP_LOAD: begin
				pot_out_q  <= '0;
				stat_out_q <= cmd.full ? ST_FULL : ST_OK;
			end
			OP_LATCH: begin
				p_q   <= coords;
				pot_q <= '0;
				sat_q <= 1'b0;
			end
			OP_MUL_LIM, OP_MUL_SQ, OP_MUL_DEN, OP_MUL_U, OP_MUL_V:
				prod_q <= {32'b0, ma} * {32'b0, mb};
			OP_SET_LIM: lim_q <= prod_q;
			OP_DIF_MID, OP_DIF_PT: begin
				for (int k = 0; k < 3; k++) dif_q[k] <= dif_nxt[k];
			end
			OP_ACC: acc_q <= (cmd.clr ? 128'b0 : acc_q) + acc_add;
			OP_BEST: begin
				if (cmd.first || acc_q[65:0] < best_q) best_q <= acc_q[65:0];
			end
			OP_CHK: begin
				x_q   <= acc_q[63:0];
				res_q <= '0;
				bit_q <= 64'h4000_0000_0000_0000;
			end
			OP_SQRT: begin
				if (x_q >= root_try) begin
					x_q   <= x_q - root_try;
					res_q <= (res_q >> 1) + bit_q;
				end else begin
					res_q <= res_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
			OP_DIV_INIT: begin
				den_q <= prod_q;
				rem_q <= '0;
				quo_q <= {31'(repel_range_q - res_q[30:0]),
					{(2 * COORD_FRAC_BITS){1'b0}}};
			end
			OP_DIV: begin
				if (rem_sh >= den_q) begin
					rem_q <= rem_sh - den_q;
					quo_q <= {quo_q[NW-2:0], 1'b1};
				end else begin
					rem_q <= rem_sh;
					quo_q <= {quo_q[NW-2:0], 1'b0};
				end
			end
			OP_SET_V: v_q <= cmd.attract ? {62'b0, best_q} : acc_q;
			OP_ADD_TERM: begin
				pot_q <= pot_q + PW'(term);
				sat_q <= sat_q | tsat;
			end
			OP_RES_Q: begin
				pot_out_q  <= pot_big ? POT_MAX : pot_q[47:0];
				stat_out_q <= (sat_q || pot_big) ? ST_SAT : ST_OK;
			end
			default: ;
		endcase
	end

endmodule

FILE: sv/lpfe_chk.sv
`timescale 1ns / 1ps
// Port-level checker for the lane potential field evaluator, bound to the
// top level. Depends on lpfe_pkg.
module lpfe_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [1:0]  s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [47:0] m_tdata,
	input logic [1:0]  m_tuser
);
	import lpfe_pkg::*;

	// A stalled result beat keeps its contents.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result beat changed while stalled");

	// Clear and load beats answer in the next cycle with a zero potential.
	a_plain_res: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser != REQ_QUERY |=> m_tvalid && m_tdata == '0)
		else $error("clear or load result missing or nonzero");

	// A query occupies the block, so no beat is taken right after it.
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser == REQ_QUERY |=> !s_tready)
		else $error("beat taken while a query is in work");

	// A saturated result always carries the largest potential.
	a_sat_max: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == ST_SAT |-> m_tdata == POT_MAX)
		else $error("saturated result without full-scale potential");

endmodule

bind lane_potential_field_eval_unit lpfe_chk u_lpfe_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

FILE: bench/tb_lane_potential_field_eval_unit.sv
`timescale 1ns / 1ps
// Self-checking bench for lane_potential_field_eval_unit: a queue-fed driver, a monitor
// and an in-bench potential predictor run across several gain and range settings.
// Depends on lpfe_pkg and the unit itself.
module tb_lane_potential_field_eval_unit;
	import lpfe_pkg::*;

	typedef struct {
		lpfe_req_t   req;
		logic [31:0] x, y, z;
		bit          drain;
	} beat_t;

	typedef struct {
		logic [47:0]  pot;
		lpfe_status_t st;
	} pot_res_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [IN_DATA_W-1:0] s_tdata = '0;
	logic [IN_USER_W-1:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic [OUT_USER_W-1:0] m_tuser;
	logic cfg_we = 1'b0;
	logic [CFG_ADDR_W-1:0] cfg_addr = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;

	lane_potential_field_eval_unit DUT (.*);

	always #2 clk = ~clk;

	// Predictor state.
	logic [31:0] gain_att = ATTRACT_GAIN_RST, gain_rep = REPEL_GAIN_RST;
	logic [30:0] range_d0 = REPEL_RANGE_RST;
	logic signed [31:0] lx[LPFE_MAX_POINTS], ly[LPFE_MAX_POINTS], lz[LPFE_MAX_POINTS];
	logic signed [31:0] rx[LPFE_MAX_POINTS], ry[LPFE_MAX_POINTS], rz[LPFE_MAX_POINTS];
	int n_left = 0, n_right = 0;

	beat_t    pending[$];
	pot_res_t expected_pot[$];
	int  errors = 0;
	bit  calm = 0;
	int  results_seen = 0;

	function automatic logic [127:0] sq_dist(logic signed [33:0] px, py, pz,
			logic signed [33:0] qx, qy, qz);
		logic signed [34:0] d[3];
		logic [127:0] s;
		d[0] = px - qx; d[1] = py - qy; d[2] = pz - qz;
		s = '0;
		for (int i = 0; i < 3; i++) begin
			if (d[i] < 0) d[i] = -d[i];
			s += 128'(d[i]) * 128'(d[i]);
		end
		return s;
	endfunction

	function automatic logic [47:0] scale_gain(logic [127:0] v, logic [31:0] k, ref bit sat);
		logic [159:0] p;
		p = ({32'b0, v} * {128'b0, k}) >> (GAIN_FRAC_BITS + 1 + LPFE_FRAC_BITS);
		if (p > 160'(POT_MAX)) begin
			sat = 1;
			return POT_MAX;
		end
		return p[47:0];
	endfunction

	function automatic logic [63:0] int_sqrt(logic [63:0] x);
		logic [63:0] res, b;
		res = 0; b = 64'd1 << 62;
		while (b > x) b >>= 2;
		while (b != 0) begin
			if (x >= res + b) begin
				x -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	function automatic logic [47:0] repulsion(logic signed [31:0] px, py, pz,
			logic signed [31:0] qx, qy, qz, ref bit sat);
		logic [127:0] d2, num, q;
		logic [63:0] d0, d, lim;
		d0 = 64'(range_d0);
		d2 = sq_dist(px, py, pz, qx, qy, qz);
		if (d0 == 0 || d2[127:64] != 0) return 0;
		lim = (d0 + 1) * (d0 + 1);
		if (d2[63:0] >= lim) return 0;
		d = int_sqrt(d2[63:0]);
		if (d == 0 || d > d0) return 0;
		num = 128'(d0 - d) << (2 * LPFE_FRAC_BITS);
		q = num / 128'(d * d0);
		return scale_gain(128'(q[63:0]) * 128'(q[63:0]), gain_rep, sat);
	endfunction

	function automatic pot_res_t eval_beat(beat_t b);
		pot_res_t r;
		logic [127:0] best, cur;
		logic [63:0] acc;
		bit sat;
		int n;
		r.pot = '0; r.st = ST_OK; sat = 0; acc = 0;
		case (b.req)
			REQ_CLEAR: begin
				n_left = 0; n_right = 0;
			end
			REQ_LOAD_L: begin
				if (n_left < LPFE_MAX_POINTS) begin
					lx[n_left] = b.x; ly[n_left] = b.y; lz[n_left] = b.z; n_left++;
				end else r.st = ST_FULL;
			end
			REQ_LOAD_R: begin
				if (n_right < LPFE_MAX_POINTS) begin
					rx[n_right] = b.x; ry[n_right] = b.y; rz[n_right] = b.z; n_right++;
				end else r.st = ST_FULL;
			end
			default: begin
				n = n_left < n_right ? n_left : n_right;
				best = '0;
				for (int i = 0; i < n; i++) begin
					// Centerline coordinates are floored midpoints.
					cur = sq_dist($signed(b.x), $signed(b.y), $signed(b.z),
						(34'(lx[i]) + 34'(rx[i])) >>> 1,
						(34'(ly[i]) + 34'(ry[i])) >>> 1,
						(34'(lz[i]) + 34'(rz[i])) >>> 1);
					if (i == 0 || cur < best) best = cur;
				end
				if (n > 0) acc += scale_gain(best, gain_att, sat);
				for (int i = 0; i < n_left; i++)
					acc += repulsion(b.x, b.y, b.z, lx[i], ly[i], lz[i], sat);
				for (int i = 0; i < n_right; i++)
					acc += repulsion(b.x, b.y, b.z, rx[i], ry[i], rz[i], sat);
				if (acc > 64'(POT_MAX)) begin
					acc = POT_MAX; sat = 1;
				end
				r.pot = acc[47:0];
				r.st = sat ? ST_SAT : ST_OK;
			end
		endcase
		return r;
	endfunction

	// Driver: offers the head of the pending queue after a random gap, or none when calm.
	int  send_wait = 0;
	int  sw;
	beat_t nxt;
	beat_t cur_beat;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			send_wait <= 0;
		end else if (!s_tvalid || s_tready) begin
			sw = send_wait;
			if (s_tvalid) begin
				expected_pot = {expected_pot, eval_beat(cur_beat)};
				sw = calm ? 0 : $urandom_range(0, 11);
			end
			if (sw > 0) begin
				s_tvalid <= 1'b0;
				send_wait <= sw - 1;
			end else if (pending.size() > 0 &&
					!(pending[0].drain && (expected_pot.size() > 0 || s_tvalid))) begin
				nxt = pending.pop_front();
				cur_beat = nxt;
				s_tdata <= {nxt.z, nxt.y, nxt.x};
				s_tuser <= nxt.req;
				s_tvalid <= 1'b1;
				send_wait <= 0;
			end else begin
				s_tvalid <= 1'b0;
				send_wait <= 0;
			end
		end
	end

	// Monitor: checks each result beat and paces m_tready.
	int recv_wait = 0;
	int rw;
	pot_res_t want;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			recv_wait <= 0;
		end else begin
			rw = recv_wait;
			if (m_tvalid && m_tready) begin
				results_seen++;
				if (expected_pot.size() == 0) begin
					$display("%0t: unexpected result pot=%h st=%0d", $time, m_tdata, m_tuser);
					errors++;
				end else begin
					want = expected_pot.pop_front();
					if (m_tdata !== want.pot) begin
						$display("%0t: potential expected %h actual %h", $time, want.pot, m_tdata);
						errors++;
					end
					if (m_tuser !== want.st) begin
						$display("%0t: status expected %0d actual %0d", $time, want.st, m_tuser);
						errors++;
					end
				end
				// One long hold-off lets the input side back up.
				rw = (results_seen == 150) ? 600 : (calm ? 0 : $urandom_range(0, 11));
			end else if (rw > 0) begin
				rw--;
			end
			recv_wait <= rw;
			m_tready <= (rw == 0);
		end
	end

	task automatic add_beat(lpfe_req_t req, logic [31:0] x, y, z, bit drain = 0);
		beat_t b;
		b.req = req; b.x = x; b.y = y; b.z = z; b.drain = drain;
		pending = {pending, b};
	endtask

	function automatic logic [31:0] near_coord(logic [31:0] base);
		if ($urandom_range(0, 7) == 0) return $urandom;
		return base + $urandom_range(0, 32'h4_0000) - 32'h2_0000;
	endfunction

	task automatic cfg_write(lpfe_cfg_idx_t idx, logic [31:0] v);
		@(posedge clk);
		cfg_we <= 1'b1; cfg_addr <= idx; cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_ATTRACT_GAIN: gain_att = v;
			CFG_REPEL_GAIN:   gain_rep = v;
			default:          range_d0 = v[30:0];
		endcase
	endtask

	task automatic drain_all();
		wait (pending.size() == 0 && !s_tvalid && expected_pot.size() == 0);
		repeat (8) @(posedge clk);
	endtask

	// A few lane points (rarely past full) around a base, then queries near it.
	task automatic lane_sequence(int budget);
		logic [31:0] bx, by, bz;
		int nl, nr, made;
		made = 0;
		while (made < budget) begin
			bx = $urandom; by = $urandom; bz = $urandom;
			if ($urandom_range(0, 3) != 0) begin
				bx = near_coord(0); by = near_coord(0); bz = near_coord(0);
			end
			if ($urandom_range(0, 9) == 0) begin
				// noise beats
				repeat (3) add_beat(lpfe_req_t'($urandom_range(0, 3)),
					$urandom, $urandom, $urandom);
				made += 3;
			end
			add_beat(REQ_CLEAR, $urandom, $urandom, $urandom);
			if ($urandom_range(0, 30) == 0) begin
				nl = 66; nr = 65;
			end else begin
				nl = $urandom_range(0, 8); nr = $urandom_range(0, 8);
			end
			for (int i = 0; i < nl || i < nr; i++) begin
				if (i < nl) add_beat(REQ_LOAD_L, near_coord(bx), near_coord(by), near_coord(bz));
				if (i < nr) add_beat(REQ_LOAD_R, near_coord(bx), near_coord(by), near_coord(bz));
			end
			made += 1 + nl + nr;
			repeat ($urandom_range(1, 4)) begin
				add_beat(REQ_QUERY, near_coord(bx), near_coord(by), near_coord(bz),
					$urandom_range(0, 40) == 0);
				made++;
			end
		end
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed beats at reset settings and extremes.
		add_beat(REQ_QUERY, 32'h0, 32'h0, 32'h0);
		add_beat(REQ_LOAD_L, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0);
		add_beat(REQ_QUERY, 32'h0, 32'h0, 32'h0);
		add_beat(REQ_LOAD_R, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
		add_beat(REQ_QUERY, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		add_beat(REQ_QUERY, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		add_beat(REQ_CLEAR, 32'h0, 32'h0, 32'h0);
		add_beat(REQ_LOAD_L, 32'h0001_0000, 32'h0, 32'h0);
		add_beat(REQ_LOAD_R, 32'hFFFF_0000, 32'h0, 32'h0);
		// Query on top of a stored point, at exactly d0, and just inside it.
		add_beat(REQ_QUERY, 32'h0001_0000, 32'h0, 32'h0);
		add_beat(REQ_QUERY, 32'h0001_8000, 32'h0, 32'h0);
		add_beat(REQ_QUERY, 32'h0001_7FFF, 32'h0, 32'h0);
		add_beat(REQ_QUERY, 32'h0000_0001, 32'h0, 32'h0, 1);
		add_beat(REQ_CLEAR, 32'h0, 32'h0, 32'h0);
		add_beat(REQ_QUERY, 32'h0001_0000, 32'h0, 32'h0);
		drain_all();

		// Settings: reset, max gains and range, zero gains, tiny range, zero range, random.
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				1: begin
					cfg_write(CFG_ATTRACT_GAIN, 32'hFFFF_FFFF);
					cfg_write(CFG_REPEL_GAIN, 32'hFFFF_FFFF);
					cfg_write(CFG_REPEL_RANGE, 32'h7FFF_FFFF);
				end
				2: begin
					cfg_write(CFG_ATTRACT_GAIN, 32'h0);
					cfg_write(CFG_REPEL_GAIN, 32'h0);
				end
				3: begin
					cfg_write(CFG_ATTRACT_GAIN, $urandom);
					cfg_write(CFG_REPEL_GAIN, $urandom);
					cfg_write(CFG_REPEL_RANGE, 32'h1);
				end
				4: begin
					cfg_write(CFG_REPEL_RANGE, 32'h0);
					cfg_write(CFG_REPEL_GAIN, 32'hFFFF_FFFF);
				end
				5: begin
					cfg_write(CFG_ATTRACT_GAIN, $urandom_range(0, 32'h4_0000));
					cfg_write(CFG_REPEL_GAIN, $urandom);
					cfg_write(CFG_REPEL_RANGE, $urandom_range(32'h4000, 32'h4_0000));
				end
				default: ;
			endcase
			if (ph == 1) begin
				// Saturating query far from the stored lane, then a query close to it.
				add_beat(REQ_CLEAR, 32'h0, 32'h0, 32'h0);
				add_beat(REQ_LOAD_L, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
				add_beat(REQ_LOAD_R, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
				add_beat(REQ_QUERY, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
				add_beat(REQ_QUERY, 32'h8000_0100, 32'h8000_0000, 32'h8000_0000);
			end
			calm = (ph == 2);
			lane_sequence(270);
			drain_all();
		end

		repeat (40) @(posedge clk);
		if (errors == 0 && expected_pot.size() == 0)
			$display("tb_lane_potential_field_eval_unit: clean");
		else
			$display("tb_lane_potential_field_eval_unit: errors");
		$finish;
	end

	initial begin
		#80ms;
		$display("tb_lane_potential_field_eval_unit: errors");
		$finish;
	end

endmodule

FILE: filelist.f
sv/lpfe_pkg.sv
sv/lpfe_ctrl.sv
sv/lpfe_dp.sv
sv/lane_potential_field_eval_unit.sv
sv/lpfe_chk.sv
bench/tb_lane_potential_field_eval_unit.sv
